// File: src/plpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plpa_pkg;

    localparam int LINE_BYTES = 64;
    localparam int POS_W      = $clog2(LINE_BYTES);
    localparam int LEN_W      = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W     = $clog2(2 * LINE_BYTES);
    localparam int CMP_W      = (LEN_W > 7) ? LEN_W : 7;

    localparam logic [7:0] CHAR_CR          = 8'd13;
    localparam logic [7:0] CHAR_LF          = 8'd10;
    localparam logic [7:0] EXTRA_TERM_RESET = 8'd62;

    typedef enum logic [1:0] {
        FUNC_RX      = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    localparam logic CFG_EXTRA_TERM_ENABLE = 1'b0;
    localparam logic CFG_EXTRA_TERM_CHAR   = 1'b1;

    typedef struct packed {
        logic              line_done;
        logic              line_ready;
        logic              ready_bank;
        logic [LEN_W-1:0]  ready_length;
        logic              rd_hit;
    } plpa_status_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } plpa_mem_req_t;

endpackage

`default_nettype wire

// File: src/plpa_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module plpa_mem (
    input  wire logic                   clk,
    input  wire plpa_pkg::plpa_mem_req_t req,
    output logic [7:0]                  rd_data
);
    import plpa_pkg::*;

    logic [7:0] store [2 * LINE_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= store[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/plpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module plpa_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire logic [1:0]              func,
    input  wire logic [7:0]              rx_byte,
    input  wire logic [5:0]              read_index,
    input  wire logic                    extra_term_enable,
    input  wire logic [7:0]              extra_term_char,
    output plpa_pkg::plpa_mem_req_t      mem_req,
    output plpa_pkg::plpa_status_t       status
);
    import plpa_pkg::*;

    logic [POS_W-1:0] write_position_reg, write_position_next;
    logic             write_bank_reg, write_bank_next;
    logic             read_bank_valid_reg, read_bank_valid_next;
    logic             read_bank_reg, read_bank_next;
    logic [LEN_W-1:0] len0_reg, len0_next;
    logic [LEN_W-1:0] len1_reg, len1_next;

    logic [LEN_W-1:0] pos_inc;
    logic             is_term;
    logic             line_end;
    logic             done;
    logic [LEN_W-1:0] cur_len;
    logic [CMP_W-1:0] idx_ext;
    logic [POS_W-1:0] idx_pos;
    logic [LEN_W-1:0] new_len;

    always_comb
    begin
        pos_inc  = LEN_W'(write_position_reg) + LEN_W'(1);
        is_term  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF)
                   || (extra_term_enable && (rx_byte == extra_term_char));
        line_end = (pos_inc == LEN_W'(LINE_BYTES)) || is_term;
        cur_len  = read_bank_reg ? len1_reg : len0_reg;
        idx_ext  = CMP_W'(read_index);
        idx_pos  = POS_W'(idx_ext);

        write_position_next  = write_position_reg;
        write_bank_next      = write_bank_reg;
        read_bank_valid_next = read_bank_valid_reg;
        read_bank_next       = read_bank_reg;
        len0_next            = len0_reg;
        len1_next            = len1_reg;
        done                 = 1'b0;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = write_bank_reg ? ADDR_W'(LINE_BYTES) + ADDR_W'(write_position_reg)
                                         : ADDR_W'(write_position_reg);
        mem_req.wr_data = rx_byte;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = read_bank_reg ? ADDR_W'(LINE_BYTES) + ADDR_W'(idx_pos)
                                        : ADDR_W'(idx_pos);
        status.rd_hit   = 1'b0;

        case (func)
            FUNC_RX:
            begin
                mem_req.wr_en = fire;
                if (line_end)
                begin
                    write_position_next = '0;
                    // a terminator as first byte is dropped
                    if (pos_inc != LEN_W'(1))
                    begin
                        done                 = 1'b1;
                        read_bank_next       = write_bank_reg;
                        read_bank_valid_next = 1'b1;
                        write_bank_next      = ~write_bank_reg;
                        if (write_bank_reg)
                        begin
                            len1_next = pos_inc;
                        end
                        else
                        begin
                            len0_next = pos_inc;
                        end
                    end
                end
                else
                begin
                    write_position_next = POS_W'(pos_inc);
                end
            end
            FUNC_RELEASE:
            begin
                if (read_bank_valid_reg)
                begin
                    // writer already on the ready bank: the other one holds a line too
                    if (read_bank_reg == write_bank_reg)
                    begin
                        read_bank_next = ~write_bank_reg;
                    end
                    else
                    begin
                        read_bank_valid_next = 1'b0;
                    end
                end
            end
            FUNC_READ:
            begin
                status.rd_hit = read_bank_valid_reg
                                && (idx_ext < CMP_W'(cur_len))
                                && (idx_ext < CMP_W'(LINE_BYTES));
                mem_req.rd_en = fire && status.rd_hit;
            end
            default:
            begin
            end
        endcase

        new_len = read_bank_next ? len1_next : len0_next;

        status.line_done    = done;
        status.line_ready   = read_bank_valid_next;
        status.ready_bank   = read_bank_valid_next && read_bank_next;
        status.ready_length = read_bank_valid_next ? new_len : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_position_reg  <= '0;
            write_bank_reg      <= 1'b0;
            read_bank_valid_reg <= 1'b0;
            read_bank_reg       <= 1'b0;
            len0_reg            <= '0;
            len1_reg            <= '0;
        end
        else if (fire)
        begin
            write_position_reg  <= write_position_next;
            write_bank_reg      <= write_bank_next;
            read_bank_valid_reg <= read_bank_valid_next;
            read_bank_reg       <= read_bank_next;
            len0_reg            <= len0_next;
            len1_reg            <= len1_next;
        end
    end

endmodule

`default_nettype wire

// File: src/ping_pong_line_assembler.sv
`timescale 1ns / 1ps
`default_nettype none

// pipeline: input register, then control and store stage, then output register
// throughput: one item per cycle unless out_stall backs up; state update, store
// write and store read all happen in the single stage after the input register
// reset: asynchronous, active low; clears control state and lengths, restores
// config defaults; the line store is not cleared

module ping_pong_line_assembler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic [7:0] rx_byte,
    input  wire logic [5:0] read_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            line_done,
    output logic            line_ready,
    output logic            ready_bank,
    output logic [6:0]      ready_length,
    output logic [7:0]      read_data,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);
    import plpa_pkg::*;

    logic        extra_term_enable_reg;
    logic [7:0]  extra_term_char_reg;

    logic        v1_reg;
    logic [1:0]  func_reg;
    logic [7:0]  rx_byte_reg;
    logic [5:0]  read_index_reg;

    logic         v2_reg;
    plpa_status_t status_reg;
    plpa_status_t status_next;

    logic        v3_reg;

    logic          adv3;
    logic          adv2;
    logic          adv1;
    logic          fire12;
    plpa_mem_req_t mem_req;
    logic [7:0]    mem_rd_data;

    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign fire12   = v1_reg && adv2;
    assign in_stall = !adv1;
    assign out_valid = v3_reg;

    plpa_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire12),
        .func              (func_reg),
        .rx_byte           (rx_byte_reg),
        .read_index        (read_index_reg),
        .extra_term_enable (extra_term_enable_reg),
        .extra_term_char   (extra_term_char_reg),
        .mem_req           (mem_req),
        .status            (status_next)
    );

    plpa_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_term_enable_reg <= 1'b0;
            extra_term_char_reg   <= EXTRA_TERM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_EXTRA_TERM_ENABLE: extra_term_enable_reg <= cfg_data[0];
                CFG_EXTRA_TERM_CHAR:   extra_term_char_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            func_reg       <= func;
            rx_byte_reg    <= rx_byte;
            read_index_reg <= read_index;
        end
        if (fire12)
        begin
            status_reg <= status_next;
        end
        if (adv3 && v2_reg)
        begin
            line_done    <= status_reg.line_done;
            line_ready   <= status_reg.line_ready;
            ready_bank   <= status_reg.ready_bank;
            ready_length <= 7'(status_reg.ready_length);
            // store data is only meaningful on a hit
            read_data    <= status_reg.rd_hit ? mem_rd_data : 8'd0;
        end
    end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import plpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 200;

    typedef struct packed {
        logic       line_done;
        logic       line_ready;
        logic       ready_bank;
        logic [6:0] ready_length;
        logic [7:0] read_data;
    } line_status_t;

    // tracks both banks and predicts the status that each item produces
    class line_assembly_board;
        bit [7:0]     line_mem [2*LINE_BYTES];
        int unsigned  fill_pos;
        bit           fill_bank;
        bit           ready_valid;
        bit           ready_sel;
        int unsigned  bank_len [2];
        bit           term_en;
        bit [7:0]     term_char;
        line_status_t expected_status [$];
        int unsigned  mismatches;

        function new();
            foreach (line_mem[i])
                line_mem[i] = 8'd0;
            fill_pos    = 0;
            fill_bank   = 1'b0;
            ready_valid = 1'b0;
            ready_sel   = 1'b0;
            bank_len[0] = 0;
            bank_len[1] = 0;
            term_en     = 1'b0;
            term_char   = EXTRA_TERM_RESET;
            mismatches  = 0;
        endfunction

        function bit ends_line(bit [7:0] b);
            return b == CHAR_CR || b == CHAR_LF || (term_en && b == term_char);
        endfunction

        function void set_register(logic idx, bit [7:0] value);
            if (idx == CFG_EXTRA_TERM_ENABLE)
                term_en = value[0];
            else
                term_char = value;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_item(func_t op, bit [7:0] rx, bit [5:0] idx);
            line_status_t st;
            int unsigned  pos;
            st = '0;
            case (op)
                FUNC_RX:
                begin
                    pos = (fill_pos >= LINE_BYTES) ? 0 : fill_pos;
                    line_mem[fill_bank * LINE_BYTES + pos] = rx;
                    pos++;
                    if (pos >= LINE_BYTES || ends_line(rx))
                    begin
                        // a terminator as first byte is dropped
                        if (pos != 1)
                        begin
                            ready_sel           = fill_bank;
                            ready_valid         = 1'b1;
                            bank_len[fill_bank] = pos;
                            fill_bank           = ~fill_bank;
                            st.line_done        = 1'b1;
                        end
                        fill_pos = 0;
                    end
                    else
                        fill_pos = pos;
                end
                FUNC_RELEASE:
                begin
                    if (ready_valid)
                    begin
                        if (ready_sel == fill_bank)
                            ready_sel = ~fill_bank;
                        else
                            ready_valid = 1'b0;
                    end
                end
                FUNC_READ:
                begin
                    if (ready_valid && idx < bank_len[ready_sel])
                        st.read_data = line_mem[ready_sel * LINE_BYTES + idx];
                end
                default:
                    ;
            endcase
            st.line_ready = ready_valid;
            if (ready_valid)
            begin
                st.ready_bank   = ready_sel;
                st.ready_length = 7'(bank_len[ready_sel]);
            end
            expected_status.push_back(st);
        endfunction

        function void check_status(line_status_t got);
            line_status_t want;
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected status: done=%0d ready=%0d bank=%0d len=%0d data=%02h",
                             got.line_done, got.line_ready, got.ready_bank,
                             got.ready_length, got.read_data);
                return;
            end
            want = expected_status.pop_front();
            if (got.line_done !== want.line_done || got.line_ready !== want.line_ready ||
                got.ready_bank !== want.ready_bank || got.ready_length !== want.ready_length ||
                got.read_data !== want.read_data)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected done=%0d ready=%0d bank=%0d len=%0d data=%02h",
                             want.line_done, want.line_ready, want.ready_bank,
                             want.ready_length, want.read_data);
                    $display("          got      done=%0d ready=%0d bank=%0d len=%0d data=%02h",
                             got.line_done, got.line_ready, got.ready_bank,
                             got.ready_length, got.read_data);
                end
            end
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] func       = FUNC_NOP;
    logic [7:0] rx_byte    = 8'd0;
    logic [5:0] read_index = 6'd0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic       line_done;
    logic       line_ready;
    logic       ready_bank;
    logic [6:0] ready_length;
    logic [7:0] read_data;
    logic       cfg_wr_en  = 1'b0;
    logic       cfg_index  = CFG_EXTRA_TERM_ENABLE;
    logic [7:0] cfg_data   = 8'd0;

    line_assembly_board board;
    int unsigned        items_sent   = 0;
    int unsigned        tx_idle_pct  = 0;
    int unsigned        rx_idle_pct  = 0;
    int unsigned        quiet_cycles = 0;
    bit                 hold_req     = 1'b0;
    bit                 hold_done    = 1'b0;

    ping_pong_line_assembler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_done    (line_done),
        .line_ready   (line_ready),
        .ready_bank   (ready_bank),
        .ready_length (ready_length),
        .read_data    (read_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_status(line_status_t'{line_done, line_ready, ready_bank,
                                              ready_length, read_data});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(func_t op, logic [7:0] b, logic [5:0] idx);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid   <= 1'b1;
        func       <= op;
        rx_byte    <= b;
        read_index <= idx;
        do @(posedge clk); while (in_stall);
        board.note_item(op, b, idx);
        if (op != FUNC_NOP)
            items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_terminator(bit en, bit [7:0] ch);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_EXTRA_TERM_ENABLE;
        cfg_data  <= {7'd0, en};
        @(posedge clk);
        board.set_register(CFG_EXTRA_TERM_ENABLE, {7'd0, en});
        cfg_index <= CFG_EXTRA_TERM_CHAR;
        cfg_data  <= ch;
        @(posedge clk);
        board.set_register(CFG_EXTRA_TERM_CHAR, ch);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_line();
        int unsigned len;
        int unsigned kind;
        int unsigned reads;
        logic [7:0]  b;
        logic [5:0]  idx;
        kind = $urandom_range(99);
        if (kind < 10)
            len = LINE_BYTES;
        else if (kind < 30)
            len = $urandom_range(40, 13);
        else
            len = $urandom_range(12, 1);
        for (int i = 0; i < len - 1; i++)
        begin
            do b = 8'($urandom_range(255)); while (board.ends_line(b));
            send_item(FUNC_RX, b, 6'($urandom_range(63)));
        end
        // closing byte; a full bank ends on anything
        if (len == LINE_BYTES && $urandom_range(1) == 0)
            b = 8'($urandom_range(255));
        else
            case ($urandom_range(2))
                0: b = CHAR_CR;
                1: b = CHAR_LF;
                default: b = board.term_en ? board.term_char : CHAR_LF;
            endcase
        send_item(FUNC_RX, b, 6'($urandom_range(63)));
        reads = $urandom_range(4);
        repeat (reads)
        begin
            if ($urandom_range(3) != 0)
                idx = 6'($urandom_range(len - 1));
            else
                idx = 6'($urandom_range(63));
            send_item(FUNC_READ, 8'($urandom_range(255)), idx);
        end
        if ($urandom_range(4) != 0)
            send_item(FUNC_RELEASE, 8'($urandom_range(255)), 6'($urandom_range(63)));
    endtask

    task automatic random_phase(int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_random_line();
            else if (pick < 70)
                send_item(FUNC_READ, 8'($urandom_range(255)), 6'($urandom_range(63)));
            else if (pick < 78)
                send_item(FUNC_RELEASE, 8'($urandom_range(255)), 6'($urandom_range(63)));
            else if (pick < 84)
                send_item(FUNC_NOP, 8'($urandom_range(255)), 6'($urandom_range(63)));
            else
                send_item(func_t'($urandom_range(3)), 8'($urandom_range(255)),
                          6'($urandom_range(63)));
        end
    endtask

    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default terminators only: '>' is plain data here
        send_item(FUNC_READ, 8'h00, 6'd0);
        send_item(FUNC_RELEASE, 8'hFF, 6'd63);
        send_item(FUNC_NOP, 8'hFF, 6'd63);
        send_item(FUNC_RX, CHAR_CR, 6'd0);
        send_item(FUNC_RX, 8'h00, 6'd0);
        send_item(FUNC_RX, 8'hFF, 6'd0);
        send_item(FUNC_RX, EXTRA_TERM_RESET, 6'd0);
        send_item(FUNC_RX, CHAR_LF, 6'd0);
        send_item(FUNC_READ, 8'h00, 6'd0);
        send_item(FUNC_READ, 8'h00, 6'd2);
        send_item(FUNC_READ, 8'h00, 6'd3);
        send_item(FUNC_READ, 8'h00, 6'd63);
        send_item(FUNC_RELEASE, 8'h00, 6'd0);
        drain();

        set_terminator(1'b1, EXTRA_TERM_RESET);
        send_item(FUNC_RX, EXTRA_TERM_RESET, 6'd0);
        send_item(FUNC_RX, 8'h55, 6'd0);
        send_item(FUNC_RX, EXTRA_TERM_RESET, 6'd0);
        send_item(FUNC_READ, 8'h00, 6'd1);
        send_item(FUNC_READ, 8'h00, 6'h2A);
        send_item(FUNC_RELEASE, 8'h00, 6'd0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_terminator(1'b1, 8'h00);
                1: set_terminator(1'b1, 8'hFF);
                2: set_terminator(1'b0, 8'hFF);
                3: set_terminator(1'b1, 8'($urandom_range(255)));
                4: set_terminator(1'b1, CHAR_CR);
                default: set_terminator(1'b1, EXTRA_TERM_RESET);
            endcase
            case (phase / 2)
                0:
                begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 64;
                end
                1:
                begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 16;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // back up the output so the block fills and stalls its input
            if (phase == 4)
                hold_req = 1'b1;
            random_phase(PHASE_ITEMS);
            drain();
        end

        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
src/plpa_pkg.sv
src/plpa_mem.sv
src/plpa_ctrl.sv
src/ping_pong_line_assembler.sv
sim/tb_top.sv
